### hw/rtl/sfrl_pkg.sv
// sfrl_pkg: sizes, codes and shared types of the sorted free region list
// used by the channel interfaces, the list cell and the top level
`default_nettype none

package sfrl_pkg;

    // table geometry
    localparam int MAX_REGIONS = 64;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int OFF_W       = 16;
    localparam int SIZE_W      = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;

    // operation wave that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic              vld;
        logic [KIND_W-1:0] kind;
        logic              drop;      // insert into a full table
        logic              done;      // placed or matched
        logic              shift;     // insert is moving later entries up
        t_cnt              rem;       // used entries from this cell on
        logic [OFF_W-1:0]  key_off;   // insert carry or query key
        logic [SIZE_W-1:0] key_size;  // insert carry or alloc request
        logic [OFF_W-1:0]  res_off;
        logic              has_prev;
        logic [OFF_W-1:0]  last_off;
        logic [OFF_W-1:0]  prev_off;
        logic              prev_vld;
        logic [OFF_W-1:0]  next_off;
        logic              next_vld;
    } t_wave;

    // one response transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    alloc_offset;
        logic [OFF_W-1:0]    prev_offset;
        logic                prev_valid;
        logic [OFF_W-1:0]    next_offset;
        logic                next_valid;
    } t_rsp;

endpackage

`default_nettype wire

### hw/rtl/sfrl_in_if.sv
// sfrl_in_if: request channel of the sorted free region list
// depends on sfrl_pkg for field widths
`default_nettype none

interface sfrl_in_if;
    logic                         valid;
    logic                         ready;
    logic [sfrl_pkg::KIND_W-1:0]  kind;
    logic [sfrl_pkg::OFF_W-1:0]   offset;
    logic [sfrl_pkg::SIZE_W-1:0]  size;

    modport source (output valid, kind, offset, size, input ready);
    modport sink   (input valid, kind, offset, size, output ready);
endinterface

`default_nettype wire

### hw/rtl/sfrl_out_if.sv
// sfrl_out_if: response channel of the sorted free region list
// depends on sfrl_pkg for field widths
`default_nettype none

interface sfrl_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfrl_pkg::STATUS_W-1:0] status;
    logic [sfrl_pkg::OFF_W-1:0]    alloc_offset;
    logic [sfrl_pkg::OFF_W-1:0]    prev_offset;
    logic                          prev_valid;
    logic [sfrl_pkg::OFF_W-1:0]    next_offset;
    logic                          next_valid;

    modport source (output valid, status, alloc_offset, prev_offset, prev_valid,
                    next_offset, next_valid, input ready);
    modport sink   (input valid, status, alloc_offset, prev_offset, prev_valid,
                    next_offset, next_valid, output ready);
endinterface

`default_nettype wire

### hw/rtl/sfrl_cell.sv
// sfrl_cell: one table slot (offset, size) plus its stage of the operation wave
// depends on sfrl_pkg for the wave type and codes
`default_nettype none

module sfrl_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire sfrl_pkg::t_wave       i_wave,
    input  wire [sfrl_pkg::OFF_W-1:0]  i_right_off,
    input  wire [sfrl_pkg::SIZE_W-1:0] i_right_size,
    output sfrl_pkg::t_wave            o_wave,
    output logic [sfrl_pkg::OFF_W-1:0]  o_off,
    output logic [sfrl_pkg::SIZE_W-1:0] o_size
);
    import sfrl_pkg::*;

    logic [OFF_W-1:0]  r_off;
    logic [SIZE_W-1:0] r_size;
    logic [OFF_W-1:0]  n_off;
    logic [SIZE_W-1:0] n_size;
    t_wave             r_wave;
    t_wave             n_wave;
    logic              cell_used;

    assign cell_used = (i_wave.rem != '0);

    // act on the wave as it passes this slot
    always_comb begin
        n_wave = i_wave;
        n_off  = r_off;
        n_size = r_size;
        if (i_wave.vld) begin
            case (i_wave.kind)
                KIND_INSERT: begin
                    if (!i_wave.drop && !i_wave.done) begin
                        if (!cell_used) begin
                            // first free slot takes the carried entry
                            n_off       = i_wave.key_off;
                            n_size      = i_wave.key_size;
                            n_wave.done = 1'b1;
                        end else if (i_wave.shift || r_off > i_wave.key_off) begin
                            // swap: carried entry lands here, old one moves on
                            n_off           = i_wave.key_off;
                            n_size          = i_wave.key_size;
                            n_wave.key_off  = r_off;
                            n_wave.key_size = r_size;
                            n_wave.shift    = 1'b1;
                        end
                    end
                end
                KIND_ALLOC: begin
                    if (i_wave.done) begin
                        // close the gap behind the removed entry
                        n_off  = i_right_off;
                        n_size = i_right_size;
                    end else if (cell_used && r_size >= i_wave.key_size) begin
                        n_wave.done    = 1'b1;
                        n_wave.res_off = r_off;
                        n_off          = i_right_off;
                        n_size         = i_right_size;
                    end
                end
                KIND_QUERY: begin
                    if (!i_wave.done && cell_used && r_off == i_wave.key_off) begin
                        n_wave.done     = 1'b1;
                        n_wave.prev_vld = i_wave.has_prev;
                        n_wave.prev_off = i_wave.has_prev ? i_wave.last_off : '0;
                        if (i_wave.rem > t_cnt'(1)) begin
                            n_wave.next_vld = 1'b1;
                            n_wave.next_off = i_right_off;
                        end
                    end
                end
                default: begin
                end
            endcase
            // bookkeeping for the next slot
            if (cell_used) begin
                n_wave.last_off = r_off;
                n_wave.has_prev = 1'b1;
                n_wave.rem      = i_wave.rem - t_cnt'(1);
            end
        end
    end

    // wave stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.vld <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_off  <= n_off;
        r_size <= n_size;
    end

    assign o_wave = r_wave;
    assign o_off  = r_off;
    assign o_size = r_size;

endmodule

`default_nettype wire

### hw/rtl/sorted_free_region_list.sv
// sorted_free_region_list: first-fit free region table built as a chain of cells
// depends on sfrl_pkg, sfrl_in_if, sfrl_out_if and sfrl_cell
//
//  channel | dir | fields                                              | handshake
//  i_req   | in  | kind, offset, size                                  | valid/ready
//  o_rsp   | out | status, alloc_offset, prev_offset/valid, next_*     | valid/ready
//
// each transaction walks the cell row one slot per cycle: the accepted request is
// registered at the head of the row, passes the wave stage of every cell and its
// response is registered in the output register; one request in flight at a time
// a finished response waits in an output register plus one skid entry, so the
// next request is taken while a response is still pending
// reset clears the entry count and control flags; the slots are not cleared
`default_nettype none

module sorted_free_region_list (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sfrl_in_if.sink      i_req,
    sfrl_out_if.source   o_rsp
);
    import sfrl_pkg::*;

    t_wave             w_wave [MAX_REGIONS+1];
    logic [OFF_W-1:0]  w_off  [MAX_REGIONS+1];
    logic [SIZE_W-1:0] w_size [MAX_REGIONS+1];

    t_wave r_inj;
    t_wave n_inj;
    t_cnt  r_count;
    logic  r_busy;
    logic  r_o_vld;
    t_rsp  r_o;
    logic  r_s_vld;
    t_rsp  r_s;
    t_rsp  end_rsp;
    t_wave w_end;
    logic  in_take;
    logic  out_take;

    assign in_take  = i_req.valid && i_req.ready;
    assign out_take = r_o_vld && o_rsp.ready;
    assign i_req.ready = !r_busy && !r_s_vld;

    // cell row, the wave enters at slot 0
    assign w_wave[0]           = r_inj;
    assign w_off[MAX_REGIONS]  = '0;
    assign w_size[MAX_REGIONS] = '0;

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        sfrl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wave       (w_wave[g]),
            .i_right_off  (w_off[g+1]),
            .i_right_size (w_size[g+1]),
            .o_wave       (w_wave[g+1]),
            .o_off        (w_off[g]),
            .o_size       (w_size[g])
        );
    end

    assign w_end = w_wave[MAX_REGIONS];

    // response built from the wave leaving the last slot
    always_comb begin
        end_rsp.alloc_offset = w_end.res_off;
        end_rsp.prev_offset  = w_end.prev_off;
        end_rsp.prev_valid   = w_end.prev_vld;
        end_rsp.next_offset  = w_end.next_off;
        end_rsp.next_valid   = w_end.next_vld;
        case (w_end.kind)
            KIND_INSERT: end_rsp.status = w_end.drop ? ST_FULL : ST_OK;
            KIND_ALLOC:  end_rsp.status = w_end.done ? ST_OK : ST_NOT_FOUND;
            KIND_QUERY:  end_rsp.status = w_end.done ? ST_OK : ST_NOT_FOUND;
            default:     end_rsp.status = ST_NOT_FOUND;
        endcase
    end

    // next wave at the head of the row
    always_comb begin
        n_inj          = '0;
        n_inj.vld      = in_take;
        n_inj.kind     = i_req.kind;
        n_inj.drop     = (i_req.kind == KIND_INSERT) &&
                         (r_count == t_cnt'(MAX_REGIONS));
        n_inj.rem      = r_count;
        n_inj.key_off  = i_req.offset;
        n_inj.key_size = i_req.size;
    end

    // wave injection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.vld <= 1'b0;
        end else begin
            r_inj <= n_inj;
        end
    end

    // busy flag and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            if (in_take) begin
                r_busy <= 1'b1;
            end else if (w_end.vld) begin
                r_busy <= 1'b0;
            end
            if (w_end.vld) begin
                if (w_end.kind == KIND_INSERT && !w_end.drop) begin
                    r_count <= r_count + t_cnt'(1);
                end else if (w_end.kind == KIND_ALLOC && w_end.done) begin
                    r_count <= r_count - t_cnt'(1);
                end
            end
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (w_end.vld) begin
            if (!r_o_vld || out_take) begin
                r_o_vld <= 1'b1;
                r_o     <= end_rsp;
            end else begin
                r_s_vld <= 1'b1;
                r_s     <= end_rsp;
            end
        end else if (out_take) begin
            r_o_vld <= r_s_vld;
            r_o     <= r_s;
            r_s_vld <= 1'b0;
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.status       = r_o.status;
    assign o_rsp.alloc_offset = r_o.alloc_offset;
    assign o_rsp.prev_offset  = r_o.prev_offset;
    assign o_rsp.prev_valid   = r_o.prev_valid;
    assign o_rsp.next_offset  = r_o.next_offset;
    assign o_rsp.next_valid   = r_o.next_valid;

`ifndef ASSERT_OFF
    // entry count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_REGIONS))
        else $error("entry count beyond table size");

    // a wave only leaves the row while a transaction is in flight
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.vld |-> r_busy)
        else $error("wave left the row with no transaction in flight");

    // an accepted request makes the block busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_busy)
        else $error("accepted request did not start a wave");

    // the skid entry is only used behind a full output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_vld |-> r_o_vld)
        else $error("skid entry holds a response ahead of the output");
`endif

endmodule

`default_nettype wire

### bench/free_list_monitor.sv
// free_list_monitor: watches the request and response channels of the sorted
// free region list, predicts each response and compares it field by field
// depends on sfrl_pkg, sfrl_in_if and sfrl_out_if
module free_list_monitor (
    input  wire     i_clk,
    input  wire     i_rst_n,
    sfrl_in_if      req,
    sfrl_out_if     rsp,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfrl_pkg::*;

    // shadow copy of the region table
    logic [OFF_W-1:0]  region_start [MAX_REGIONS];
    logic [SIZE_W-1:0] region_len   [MAX_REGIONS];
    int                region_cnt = 0;

    // responses still owed by the block, oldest first
    t_rsp owed_rsp_q[$];
    int   mismatch_cnt = 0;
    int   rsp_cnt = 0;

    // apply one request to the shadow table and return the response it owes
    function automatic t_rsp apply_request(input logic [KIND_W-1:0] kind,
                                           input logic [OFF_W-1:0]  off,
                                           input logic [SIZE_W-1:0] size);
        t_rsp r;
        int   pos;
        int   k;
        r        = '0;
        r.status = ST_NOT_FOUND;
        case (kind)
            KIND_INSERT: begin
                if (region_cnt >= MAX_REGIONS) begin
                    r.status = ST_FULL;
                end else begin
                    // equal offsets land after the ones already present
                    pos = 0;
                    while (pos < region_cnt && region_start[pos] <= off)
                        pos++;
                    for (k = region_cnt; k > pos; k--) begin
                        region_start[k] = region_start[k-1];
                        region_len[k]   = region_len[k-1];
                    end
                    region_start[pos] = off;
                    region_len[pos]   = size;
                    region_cnt++;
                    r.status = ST_OK;
                end
            end
            KIND_ALLOC: begin
                // first fit, whole entry removed
                for (pos = 0; pos < region_cnt; pos++) begin
                    if (region_len[pos] >= size) begin
                        r.status       = ST_OK;
                        r.alloc_offset = region_start[pos];
                        for (k = pos; k + 1 < region_cnt; k++) begin
                            region_start[k] = region_start[k+1];
                            region_len[k]   = region_len[k+1];
                        end
                        region_cnt--;
                        break;
                    end
                end
            end
            KIND_QUERY: begin
                for (pos = 0; pos < region_cnt; pos++) begin
                    if (region_start[pos] == off) begin
                        r.status = ST_OK;
                        if (pos > 0) begin
                            r.prev_offset = region_start[pos-1];
                            r.prev_valid  = 1'b1;
                        end
                        if (pos + 1 < region_cnt) begin
                            r.next_offset = region_start[pos+1];
                            r.next_valid  = 1'b1;
                        end
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            region_cnt = 0;
            owed_rsp_q.delete();
        end else begin
            // response transaction against the oldest prediction
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                if (owed_rsp_q.size() == 0) begin
                    $display("%0t ns: response with none expected, status %0h",
                             $time, rsp.status);
                    mismatch_cnt++;
                end else begin
                    want = owed_rsp_q.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("alloc_offset", want.alloc_offset, rsp.alloc_offset);
                    check_field("prev_offset", want.prev_offset, rsp.prev_offset);
                    check_field("prev_valid", 16'(want.prev_valid), 16'(rsp.prev_valid));
                    check_field("next_offset", want.next_offset, rsp.next_offset);
                    check_field("next_valid", 16'(want.next_valid), 16'(rsp.next_valid));
                    rsp_cnt++;
                end
            end
            // request transaction updates the shadow table
            if (req.valid === 1'b1 && req.ready === 1'b1)
                owed_rsp_q.insert(owed_rsp_q.size(),
                                  apply_request(req.kind, req.offset, req.size));
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= owed_rsp_q.size();
        o_checked    <= rsp_cnt;
    end

endmodule

### bench/tb.sv
// tb: top of the sorted free region list bench; drives requests and response
// back-pressure, and gives the verdict from the counts of free_list_monitor
// depends on sfrl_pkg, sfrl_in_if, sfrl_out_if, sorted_free_region_list
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfrl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;
    localparam int RANDOM_ITEMS = 1880;
    localparam int LONG_STALL   = 600;

    logic i_clk;
    logic i_rst_n;

    sfrl_in_if  req_if ();
    sfrl_out_if rsp_if ();

    int fail_count;
    int pending;
    int checked;

    int stall_request = 0;
    bit src_steady = 0;
    bit snk_steady = 0;
    int kind_count [4];
    logic [OFF_W-1:0] hot_offsets [16];

    sorted_free_region_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    free_list_monitor mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    // one request transaction after a random gap
    task automatic send_req(input logic [KIND_W-1:0] kind,
                            input logic [OFF_W-1:0]  off,
                            input logic [SIZE_W-1:0] size);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  = 1'b1;
        req_if.kind   = kind;
        req_if.offset = off;
        req_if.size   = size;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        kind_count[kind]++;
    endtask

    // hold new requests until every response is back
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [OFF_W-1:0] pick_offset();
        if ($urandom_range(0, 1) == 0)
            return hot_offsets[$urandom_range(0, 15)];
        return OFF_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_region_size();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2, 3:    return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 512));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_request_size();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(0, 600));
        endcase
    endfunction

    // response side: random back-pressure plus the long hold-off on request
    initial begin : sink_side
        int gap;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0)
                snk_steady = !snk_steady;
            gap = snk_steady ? 0 : $urandom_range(0, 4);
            if (stall_request > 0) begin
                gap           = stall_request;
                stall_request = 0;
            end
            if (gap > 0) begin
                rsp_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
        end
    end

    // stimulus
    initial begin : source_side
        logic [KIND_W-1:0] kind;
        int  roll;
        int  phase_left;
        bit  filling;
        int  n;

        req_if.valid  = 1'b0;
        req_if.kind   = KIND_INSERT;
        req_if.offset = '0;
        req_if.size   = '0;
        i_rst_n       = 1'b0;
        phase_left    = 0;
        filling       = 1'b0;
        hot_offsets   = '{16'h0000, 16'h0001, 16'h00FF, 16'h0100,
                          16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000};
        for (n = 8; n < 16; n++)
            hot_offsets[n] = OFF_W'($urandom);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: query miss, no fit, unknown kind
        send_req(KIND_QUERY, 16'h0000, 16'h0000);
        send_req(KIND_ALLOC, 16'h0000, 16'h0000);
        send_req(KIND_OTHER, 16'hFFFF, 16'hFFFF);
        // inserts with an equal offset and both offset extremes
        send_req(KIND_INSERT, 16'h0100, 16'h0010);
        send_req(KIND_INSERT, 16'hFFFF, 16'hFFFF);
        send_req(KIND_INSERT, 16'h0000, 16'h0000);
        send_req(KIND_INSERT, 16'h0100, 16'h0020);
        send_req(KIND_INSERT, 16'h8000, 16'h0001);
        send_req(KIND_INSERT, 16'h5555, 16'hAAAA);
        // neighbors: middle, first entry, last entry, miss
        send_req(KIND_QUERY, 16'h0100, 16'h0000);
        send_req(KIND_QUERY, 16'h0000, 16'hFFFF);
        send_req(KIND_QUERY, 16'hFFFF, 16'h0000);
        send_req(KIND_QUERY, 16'h1234, 16'h0000);
        // zero request, largest request, skip a small region, no fit, exact fit
        send_req(KIND_ALLOC, 16'hAAAA, 16'h0000);
        send_req(KIND_ALLOC, 16'h5555, 16'hFFFF);
        send_req(KIND_ALLOC, 16'h0000, 16'h0011);
        send_req(KIND_ALLOC, 16'h0000, 16'hAAAB);
        send_req(KIND_ALLOC, 16'h0000, 16'hAAAA);
        send_req(KIND_QUERY, 16'h8000, 16'h0000);
        send_req(KIND_OTHER, 16'h0000, 16'h0000);
        wait_drained();

        // random: alternating fill and drain phases
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(40, 140);
            end
            phase_left--;
            // pause until drained, then hold the response side off
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                stall_request = LONG_STALL;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                kind = KIND_OTHER;
            else if (filling)
                kind = (roll < 70) ? KIND_INSERT : (roll < 82) ? KIND_ALLOC : KIND_QUERY;
            else
                kind = (roll < 20) ? KIND_INSERT : (roll < 65) ? KIND_ALLOC : KIND_QUERY;
            send_req(kind, pick_offset(),
                     (kind == KIND_ALLOC) ? pick_request_size() : pick_region_size());
        end

        // wind down
        wait_drained();
        repeat (MAX_REGIONS + 8) @(posedge i_clk);
        @(negedge i_clk);
        $display("summary: %0d inserts, %0d allocates, %0d queries, %0d unknown kinds",
                 kind_count[KIND_INSERT], kind_count[KIND_ALLOC],
                 kind_count[KIND_QUERY], kind_count[KIND_OTHER]);
        $display("summary: %0d responses checked, %0d mismatches, %0d still owed",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
